### rtl/mlpc_pkg.sv
// Shared types, constants and register codes for the Morse light pulse classifier.
package mlpc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int COUNT_BITS_DEFAULT  = 16;

   localparam int THRESHOLD_W = 12;
   localparam int TICKS_W     = 16;
   localparam int CHARS_W     = 6;
   localparam int CODE_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CHARS_W-1:0] CHARS_MAX = '1;

   localparam logic [CODE_W-1:0] EV_DOT  = 2'd0;
   localparam logic [CODE_W-1:0] EV_DASH = 2'd1;
   localparam logic [CODE_W-1:0] EV_GAP  = 2'd2;
   localparam logic [CODE_W-1:0] EV_END  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DASH_TICKS      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LETTER_GAP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MSG_TIMEOUT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_CHARS       = 3'd5;

   localparam logic [THRESHOLD_W-1:0] RST_LIGHT_THRESHOLD = 12'd2048;
   localparam logic [TICKS_W-1:0]     RST_DEBOUNCE_TICKS  = 16'd10;
   localparam logic [TICKS_W-1:0]     RST_DASH_TICKS      = 16'd35;
   localparam logic [TICKS_W-1:0]     RST_LETTER_GAP      = 16'd60;
   localparam logic [TICKS_W-1:0]     RST_MSG_TIMEOUT     = 16'd400;
   localparam logic [CHARS_W-1:0]     RST_MAX_CHARS       = 6'd50;

   typedef struct packed {
      logic [THRESHOLD_W-1:0] light_threshold;
      logic [TICKS_W-1:0]     debounce_ticks;
      logic [TICKS_W-1:0]     dash_ticks;
      logic [TICKS_W-1:0]     letter_gap_ticks;
      logic [TICKS_W-1:0]     message_timeout_ticks;
      logic [CHARS_W-1:0]     max_message_chars;
   } cfg_type;

endpackage

### rtl/morse_light_pulse_classifier.sv
// Top level of the Morse light pulse classifier: configuration registers and classifier core.
// Each sample word (three readings) passes an input register, one stage of compare and count
// logic, and a result register, so a word's result (dot, dash, letter gap or message end, or
// nothing) is presented from the result register after the word has left the input register;
// the sustained rate is one word per cycle as long as results are taken. The result register
// holds a valid result while rsp_stall is high and the input register still takes one word
// behind it. Configuration writes are registered and are to be made while the block is idle.
module morse_light_pulse_classifier #(
   parameter int SAMPLE_BITS = mlpc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = mlpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mlpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mlpc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_reading_first,
   input  logic [SAMPLE_BITS-1:0]            req_reading_second,
   input  logic [SAMPLE_BITS-1:0]            req_reading_third,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mlpc_pkg::CODE_W-1:0]       rsp_event_code,
   output logic                              rsp_message_status,
   output logic [mlpc_pkg::CHARS_W-1:0]      rsp_message_chars
);

   mlpc_pkg::cfg_type cfg;

   mlpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mlpc_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_reading_first  (req_reading_first),
      .req_reading_second (req_reading_second),
      .req_reading_third  (req_reading_third),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_code     (rsp_event_code),
      .rsp_message_status (rsp_message_status),
      .rsp_message_chars  (rsp_message_chars)
   );

endmodule

### rtl/mlpc_csr.sv
// Configuration register file for the Morse light pulse classifier.
module mlpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mlpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mlpc_pkg::CSR_DATA_W-1:0]     csr_data,
   output mlpc_pkg::cfg_type                   cfg
);

   mlpc_pkg::cfg_type cfg_ff;
   mlpc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mlpc_pkg::REG_LIGHT_THRESHOLD:
               cfg_in.light_threshold = csr_data[mlpc_pkg::THRESHOLD_W-1:0];
            mlpc_pkg::REG_DEBOUNCE_TICKS:
               cfg_in.debounce_ticks = csr_data[mlpc_pkg::TICKS_W-1:0];
            mlpc_pkg::REG_DASH_TICKS:
               cfg_in.dash_ticks = csr_data[mlpc_pkg::TICKS_W-1:0];
            mlpc_pkg::REG_LETTER_GAP:
               cfg_in.letter_gap_ticks = csr_data[mlpc_pkg::TICKS_W-1:0];
            mlpc_pkg::REG_MSG_TIMEOUT:
               cfg_in.message_timeout_ticks = csr_data[mlpc_pkg::TICKS_W-1:0];
            mlpc_pkg::REG_MAX_CHARS:
               cfg_in.max_message_chars = csr_data[mlpc_pkg::CHARS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold       <= mlpc_pkg::RST_LIGHT_THRESHOLD;
         cfg_ff.debounce_ticks        <= mlpc_pkg::RST_DEBOUNCE_TICKS;
         cfg_ff.dash_ticks            <= mlpc_pkg::RST_DASH_TICKS;
         cfg_ff.letter_gap_ticks      <= mlpc_pkg::RST_LETTER_GAP;
         cfg_ff.message_timeout_ticks <= mlpc_pkg::RST_MSG_TIMEOUT;
         cfg_ff.max_message_chars     <= mlpc_pkg::RST_MAX_CHARS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/mlpc_core.sv
// Input register, level detection, pulse timing state and result register.
module mlpc_core #(
   parameter int SAMPLE_BITS = mlpc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = mlpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mlpc_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_reading_first,
   input  logic [SAMPLE_BITS-1:0]            req_reading_second,
   input  logic [SAMPLE_BITS-1:0]            req_reading_third,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mlpc_pkg::CODE_W-1:0]       rsp_event_code,
   output logic                              rsp_message_status,
   output logic [mlpc_pkg::CHARS_W-1:0]      rsp_message_chars
);

   localparam int SUM_W  = SAMPLE_BITS + 2;
   localparam int THR_W  = mlpc_pkg::THRESHOLD_W + 2;
   localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;
   localparam int TCMP_W = (COUNT_BITS > mlpc_pkg::TICKS_W) ? COUNT_BITS : mlpc_pkg::TICKS_W;

   logic                            in_valid_ff;
   logic [SAMPLE_BITS-1:0]          first_ff, second_ff, third_ff;
   logic                            level_ff, level_in;
   logic [COUNT_BITS-1:0]           ticks_ff, ticks_in;
   logic                            active_ff, active_in;
   logic [mlpc_pkg::CHARS_W-1:0]    chars_ff, chars_in;
   logic                            rsp_valid_ff;
   logic [mlpc_pkg::CODE_W-1:0]     code_ff, code_in;
   logic                            status_ff, status_in;
   logic [mlpc_pkg::CHARS_W-1:0]    rsp_chars_ff;
   logic                            produced;

   logic                            process;
   logic [SUM_W-1:0]                sum;
   logic [CMP_W-1:0]                thr_bound;
   logic                            level;
   logic [COUNT_BITS-1:0]           tick_inc;
   logic [TCMP_W-1:0]               tick_ext;
   logic [mlpc_pkg::CHARS_W-1:0]    chars_bump;

   assign process   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;

   assign sum = SUM_W'(first_ff) + SUM_W'(second_ff) + SUM_W'(third_ff);
   assign thr_bound = (CMP_W'(cfg.light_threshold) << 1) + CMP_W'(cfg.light_threshold)
                    + CMP_W'(2);
   assign level = CMP_W'(sum) > thr_bound;

   assign tick_inc   = (ticks_ff == '1) ? ticks_ff : ticks_ff + COUNT_BITS'(1);
   assign tick_ext   = TCMP_W'(tick_inc);
   assign chars_bump = (chars_ff == mlpc_pkg::CHARS_MAX) ? chars_ff
                     : chars_ff + mlpc_pkg::CHARS_W'(1);

   always_comb begin
      level_in  = level_ff;
      ticks_in  = tick_inc;
      active_in = active_ff;
      chars_in  = chars_ff;
      produced  = 1'b0;
      code_in   = mlpc_pkg::EV_DOT;
      status_in = 1'b0;
      if (level != level_ff) begin
         if (tick_ext >= TCMP_W'(cfg.debounce_ticks)) begin
            if (level_ff) begin
               chars_in  = chars_bump;
               active_in = 1'b1;
               produced  = 1'b1;
               code_in   = (tick_ext >= TCMP_W'(cfg.dash_ticks)) ? mlpc_pkg::EV_DASH
                                                                 : mlpc_pkg::EV_DOT;
            end else if (active_ff && tick_ext >= TCMP_W'(cfg.letter_gap_ticks)) begin
               chars_in = chars_bump;
               produced = 1'b1;
               code_in  = mlpc_pkg::EV_GAP;
            end
            ticks_in = '0;
            level_in = level;
         end
      end else if (active_ff && tick_ext > TCMP_W'(cfg.message_timeout_ticks)) begin
         produced  = 1'b1;
         code_in   = mlpc_pkg::EV_END;
         status_in = chars_ff > cfg.max_message_chars;
         chars_in  = '0;
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= 1'b0;
         ticks_ff     <= '0;
         active_ff    <= 1'b0;
         chars_ff     <= '0;
      end else begin
         if (!in_valid_ff || process) begin
            in_valid_ff <= req_valid;
         end
         if (process) begin
            rsp_valid_ff <= produced;
            level_ff     <= level_in;
            ticks_ff     <= ticks_in;
            active_ff    <= active_in;
            chars_ff     <= chars_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         first_ff  <= req_reading_first;
         second_ff <= req_reading_second;
         third_ff  <= req_reading_third;
      end
      if (process && produced) begin
         code_ff      <= code_in;
         status_ff    <= status_in;
         rsp_chars_ff <= chars_in == '0 ? chars_ff : chars_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_code     = code_ff;
   assign rsp_message_status = status_ff;
   assign rsp_message_chars  = rsp_chars_ff;

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (process && produced && code_in == mlpc_pkg::EV_END) |=>
         (chars_ff == '0 && !active_ff))
      else $error("message end did not clear reception state");

   a_symbol_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && code_ff != mlpc_pkg::EV_END) |-> active_ff)
      else $error("symbol or gap shown without message in progress");

   a_chars_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_chars_ff != '0))
      else $error("result shown with zero character count");

   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff) |-> (code_ff == mlpc_pkg::EV_END))
      else $error("too-long status on an event other than message end");

endmodule
